// ===== rtl/tlnf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlnf_pkg
// Shared constants, phase codes and helpers for the traffic light controller.
// ----------------------------------------------------------------------------
package tlnf_pkg;

    // Width of the tick counter and of the light sensor sample
    localparam int TICK_WIDTH  = 16;
    localparam int SENSOR_BITS = 12;

    // Register field widths
    localparam int THRESH_W = 12;
    localparam int DEBNC_W  = 8;
    localparam int SECS_W   = 4;
    localparam int PERIOD_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Compare widths, wide enough for both operands
    localparam int TICK_CMP_W  = (TICK_WIDTH + 1 > PERIOD_W) ? TICK_WIDTH + 1 : PERIOD_W;
    localparam int LIGHT_CMP_W = (SENSOR_BITS > THRESH_W) ? SENSOR_BITS : THRESH_W;
    localparam logic [LIGHT_CMP_W-1:0] SENSOR_MASK = LIGHT_CMP_W'((1 << SENSOR_BITS) - 1);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_SECONDS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_SECONDS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW_SECONDS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_HALF_MS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 3'd6;

    // Register reset values
    localparam logic [THRESH_W-1:0] RST_NIGHT_THRESHOLD  = 12'd2500;
    localparam logic [DEBNC_W-1:0]  RST_DEBOUNCE_MS      = 8'd50;
    localparam logic [SECS_W-1:0]   RST_RED_SECONDS      = 4'd5;
    localparam logic [SECS_W-1:0]   RST_GREEN_SECONDS    = 4'd6;
    localparam logic [SECS_W-1:0]   RST_YELLOW_SECONDS   = 4'd3;
    localparam logic [PERIOD_W-1:0] RST_FLASH_HALF_MS    = 16'd500;
    localparam logic [PERIOD_W-1:0] RST_TICKS_PER_SECOND = 16'd1000;

    // Phase codes
    localparam logic [1:0] PH_RED    = 2'd0;
    localparam logic [1:0] PH_GREEN  = 2'd1;
    localparam logic [1:0] PH_YELLOW = 2'd2;
    localparam logic [1:0] PH_NIGHT  = 2'd3;

    // Lamp and display word of one result
    typedef struct packed {
        logic              red_on;
        logic              yellow_on;
        logic              green_on;
        logic              show_digits;
        logic [SECS_W-1:0] countdown;
    } lamp_word_t;

    // Seconds loaded on entry to a day phase; zero counts as one second
    function automatic logic [SECS_W-1:0] phase_seconds(
        input logic [1:0]        ph,
        input logic [SECS_W-1:0] red_s,
        input logic [SECS_W-1:0] green_s,
        input logic [SECS_W-1:0] yellow_s
    );
        logic [SECS_W-1:0] s;
        case (ph)
            PH_RED:   s = red_s;
            PH_GREEN: s = green_s;
            default:  s = yellow_s;
        endcase
        return (s == '0) ? SECS_W'(1) : s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/traffic_light_night_flash_controller_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// traffic_light_night_flash_controller_core
// Day cycle red, green, yellow with countdown display, night yellow flashing
// on darkness, and a debounced button that toggles the display.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction | word
//  --------+--------------------------------------+-----------+---------------
//  in      | in_valid / in_ready                  | sink      | button, light
//  out     | out_valid / out_ready                | source    | lamps, display
//  cfg     | cfg_valid / cfg_ready                | sink      | index, data
//
//  One word per cycle sustained while the output is not stalled. A word is
//  held in the input register, then the tick logic updates the controller
//  state and loads the result register from it.
//  Reset puts the registers at their defaults and the cycle at red start.
//  A stalled result holds; the input register still takes a word while the
//  result register is full, and both stall together only when both are full.
//  The configuration port is always ready.
// ----------------------------------------------------------------------------
module traffic_light_night_flash_controller_core
    import tlnf_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,

    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire                     button_level,
    input  wire  [SENSOR_BITS-1:0]  light_level,

    output logic                    out_valid,
    input  wire                     out_ready,
    output logic                    red_on,
    output logic                    yellow_on,
    output logic                    green_on,
    output logic                    show_digits,
    output logic [SECS_W-1:0]       countdown,

    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  [CFG_IDX_W-1:0]    cfg_index,
    input  wire  [CFG_DATA_W-1:0]   cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [THRESH_W-1:0] night_threshold_reg;
    logic [DEBNC_W-1:0]  debounce_ms_reg;
    logic [SECS_W-1:0]   red_seconds_reg;
    logic [SECS_W-1:0]   green_seconds_reg;
    logic [SECS_W-1:0]   yellow_seconds_reg;
    logic [PERIOD_W-1:0] flash_half_ms_reg;
    logic [PERIOD_W-1:0] ticks_per_second_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            night_threshold_reg  <= RST_NIGHT_THRESHOLD;
            debounce_ms_reg      <= RST_DEBOUNCE_MS;
            red_seconds_reg      <= RST_RED_SECONDS;
            green_seconds_reg    <= RST_GREEN_SECONDS;
            yellow_seconds_reg   <= RST_YELLOW_SECONDS;
            flash_half_ms_reg    <= RST_FLASH_HALF_MS;
            ticks_per_second_reg <= RST_TICKS_PER_SECOND;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Writes beyond the register list are dropped
            case (cfg_index)
                REG_NIGHT_THRESHOLD:  night_threshold_reg  <= cfg_data[THRESH_W-1:0];
                REG_DEBOUNCE_MS:      debounce_ms_reg      <= cfg_data[DEBNC_W-1:0];
                REG_RED_SECONDS:      red_seconds_reg      <= cfg_data[SECS_W-1:0];
                REG_GREEN_SECONDS:    green_seconds_reg    <= cfg_data[SECS_W-1:0];
                REG_YELLOW_SECONDS:   yellow_seconds_reg   <= cfg_data[SECS_W-1:0];
                REG_FLASH_HALF_MS:    flash_half_ms_reg    <= cfg_data[PERIOD_W-1:0];
                REG_TICKS_PER_SECOND: ticks_per_second_reg <= cfg_data[PERIOD_W-1:0];
                default:              ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: input register feeds the result register
    // ------------------------------------------------------------------
    logic                   in_valid_reg;
    logic                   button_reg;
    logic [SENSOR_BITS-1:0] light_reg;
    logic                   out_valid_reg;
    lamp_word_t             result_reg;
    lamp_word_t             result_next;
    logic                   advance;
    logic                   process;

    // Result register can take a word when empty or being drained
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign process  = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            button_reg <= button_level;
            light_reg  <= light_level;
        end
        if (process)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_on      = result_reg.red_on;
    assign yellow_on   = result_reg.yellow_on;
    assign green_on    = result_reg.green_on;
    assign show_digits = result_reg.show_digits;
    assign countdown   = result_reg.countdown;

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    logic [1:0]            phase_reg,        phase_next;
    logic [TICK_WIDTH-1:0] tick_count_reg,   tick_count_next;
    logic [SECS_W-1:0]     seconds_left_reg, seconds_left_next;
    logic                  flash_lit_reg,    flash_lit_next;
    logic                  display_reg,      display_next;
    logic                  btn_stable_reg,   btn_stable_next;
    logic                  btn_prev_reg,     btn_prev_next;
    logic [DEBNC_W-1:0]    stable_cnt_reg,   stable_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_RED;
            tick_count_reg   <= '0;
            seconds_left_reg <= '0;
            flash_lit_reg    <= 1'b1;
            display_reg      <= 1'b1;
            btn_stable_reg   <= 1'b1;
            btn_prev_reg     <= 1'b1;
            stable_cnt_reg   <= '0;
        end
        else if (process)
        begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            seconds_left_reg <= seconds_left_next;
            flash_lit_reg    <= flash_lit_next;
            display_reg      <= display_next;
            btn_stable_reg   <= btn_stable_next;
            btn_prev_reg     <= btn_prev_next;
            stable_cnt_reg   <= stable_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Tick logic
    // ------------------------------------------------------------------
    logic [LIGHT_CMP_W-1:0] light_ext;
    logic [LIGHT_CMP_W-1:0] thresh_ext;
    logic                   dark;
    logic [1:0]             phase_cur;
    logic [SECS_W-1:0]      secs_cur;
    logic                   lit_cur;
    logic [PERIOD_W-1:0]    period_limit;
    logic [TICK_WIDTH:0]    tick_sum;
    logic                   period_end;
    logic [SECS_W-1:0]      secs_dec;

    always_comb
    begin
        // Debounce: count ticks of a steady raw level, then take the level
        if (button_reg != btn_prev_reg)
        begin
            stable_cnt_next = '0;
        end
        else if (stable_cnt_reg != {DEBNC_W{1'b1}})
        begin
            stable_cnt_next = stable_cnt_reg + DEBNC_W'(1);
        end
        else
        begin
            stable_cnt_next = stable_cnt_reg;
        end
        btn_prev_next   = button_reg;
        btn_stable_next = btn_stable_reg;
        display_next    = display_reg;
        if ((stable_cnt_next >= debounce_ms_reg) && (button_reg != btn_stable_reg))
        begin
            btn_stable_next = button_reg;
            // Toggle the display on a press, not on a release
            if (!button_reg)
            begin
                display_next = !display_reg;
            end
        end

        // Darkness test against the threshold, both cut to sensor width
        light_ext  = LIGHT_CMP_W'(light_reg);
        thresh_ext = LIGHT_CMP_W'(night_threshold_reg) & SENSOR_MASK;
        dark       = light_ext > thresh_ext;

        // Start of a day second: load the phase on entry, test the light
        phase_cur = phase_reg;
        secs_cur  = seconds_left_reg;
        lit_cur   = flash_lit_reg;
        if ((phase_reg != PH_NIGHT) && (tick_count_reg == '0))
        begin
            if (seconds_left_reg == '0)
            begin
                secs_cur = phase_seconds(phase_reg, red_seconds_reg,
                                         green_seconds_reg, yellow_seconds_reg);
            end
            if (dark)
            begin
                phase_cur = PH_NIGHT;
                lit_cur   = 1'b1;
                secs_cur  = '0;
            end
        end

        // Shared period counter; a zero limit ends every tick, overflow ends too
        period_limit = (phase_cur == PH_NIGHT) ? flash_half_ms_reg : ticks_per_second_reg;
        tick_sum     = {1'b0, tick_count_reg} + (TICK_WIDTH + 1)'(1);
        period_end   = (TICK_CMP_W'(tick_sum) >= TICK_CMP_W'(period_limit))
                       || tick_sum[TICK_WIDTH];
        tick_count_next = period_end ? '0 : tick_sum[TICK_WIDTH-1:0];

        secs_dec          = secs_cur - SECS_W'(1);
        phase_next        = phase_cur;
        seconds_left_next = secs_cur;
        flash_lit_next    = lit_cur;
        result_next       = '0;

        if (phase_cur == PH_NIGHT)
        begin
            result_next.yellow_on = lit_cur;
            if (period_end)
            begin
                // After a full flash, go back to red once it is light again
                flash_lit_next = !lit_cur;
                if (!lit_cur && !dark)
                begin
                    phase_next        = PH_RED;
                    seconds_left_next = '0;
                end
            end
        end
        else
        begin
            result_next.red_on      = (phase_cur == PH_RED);
            result_next.green_on    = (phase_cur == PH_GREEN);
            result_next.yellow_on   = (phase_cur == PH_YELLOW);
            result_next.show_digits = display_next;
            result_next.countdown   = display_next ? secs_cur : '0;
            if (period_end)
            begin
                seconds_left_next = secs_dec;
                if (secs_dec == '0)
                begin
                    phase_next = (phase_cur == PH_YELLOW) ? PH_RED
                                                          : phase_cur + 2'd1;
                end
            end
        end
    end

endmodule
`default_nettype wire
